### hdl/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// Shared constants and types for the parameter-change to MIDI message block.
// ----------------------------------------------------------------------------
package pcm_pkg;

	localparam int SLOT_COUNT   = 8;
	localparam int HW_SLOTS     = 8;
	localparam int ACTIVE_SLOTS = (SLOT_COUNT < HW_SLOTS) ? SLOT_COUNT : HW_SLOTS;
	localparam int SLOT_W       = $clog2(HW_SLOTS);
	localparam int VALUE_W      = 7;
	localparam int CHAN_W       = 5;

	localparam logic [7:0] ST_NOTE_OFF = 8'h80;
	localparam logic [7:0] ST_NOTE_ON  = 8'h90;
	localparam logic [7:0] ST_CTRL     = 8'hB0;

	localparam logic [VALUE_W-1:0] CTRL_BASE = 7'd32;
	localparam logic [VALUE_W-1:0] NOTE_BASE = 7'd60;
	localparam logic [VALUE_W-1:0] VEL_ON    = 7'd127;
	localparam logic [VALUE_W-1:0] VEL_OFF   = 7'd0;

	localparam logic [CHAN_W-1:0] CHAN_RESET = 5'd1;

	localparam int JOBQ_DEPTH = 2;
	localparam int JOBQ_PTR_W = (JOBQ_DEPTH > 1) ? $clog2(JOBQ_DEPTH) : 1;
	localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

	typedef logic [HW_SLOTS-1:0][VALUE_W-1:0] ctrl_vec_t;

	// one frame's work: which slots changed, plus the new values
	typedef struct packed {
		logic [HW_SLOTS-1:0] cc_mask;
		logic [HW_SLOTS-1:0] tg_mask;
		ctrl_vec_t           ctrl_value;
		logic [HW_SLOTS-1:0] trig;
	} job_t;

endpackage

### hdl/pcm_front.sv
// ----------------------------------------------------------------------------
// pcm_front
// Takes frame snapshots, compares them with the previous frame and queues a
// job holding the change masks. Frames with no change produce no job.
// ----------------------------------------------------------------------------
module pcm_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  pcm_pkg::ctrl_vec_t  ctrl_value,
	input  logic [7:0]          trigger_bits,
	input  logic                jobq_full,
	output logic                job_push,
	output pcm_pkg::job_t       job
);
	import pcm_pkg::*;

	logic [VALUE_W-1:0] prev_ctrl_q [HW_SLOTS];
	logic [HW_SLOTS-1:0] prev_trig_q;
	logic accept;

	assign full   = jobq_full;
	assign accept = push && !jobq_full;

	always_comb begin
		job.ctrl_value = ctrl_value;
		job.trig       = trigger_bits;
		for (int i = 0; i < HW_SLOTS; i++) begin
			job.cc_mask[i] = (i < ACTIVE_SLOTS) && (ctrl_value[i] != prev_ctrl_q[i]);
			job.tg_mask[i] = (i < ACTIVE_SLOTS) && (trigger_bits[i] != prev_trig_q[i]);
		end
	end

	assign job_push = accept && ((|job.cc_mask) || (|job.tg_mask));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HW_SLOTS; i++) begin
				prev_ctrl_q[i] <= '0;
			end
			prev_trig_q <= '0;
		end else if (accept) begin
			for (int i = 0; i < HW_SLOTS; i++) begin
				if (i < ACTIVE_SLOTS) begin
					prev_ctrl_q[i] <= ctrl_value[i];
					prev_trig_q[i] <= trigger_bits[i];
				end
			end
		end
	end

	a_push_has_change: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> ((|job.cc_mask) || (|job.tg_mask)))
		else $error("job queued without any change");

endmodule

### hdl/pcm_job_fifo.sv
// ----------------------------------------------------------------------------
// pcm_job_fifo
// Short queue of frame jobs between the compare front and the message back.
// ----------------------------------------------------------------------------
module pcm_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  pcm_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output logic          rd_valid,
	output pcm_pkg::job_t rd_job
);
	import pcm_pkg::*;

	job_t                  entry_q [JOBQ_DEPTH];
	logic [JOBQ_PTR_W-1:0] wr_ptr_q;
	logic [JOBQ_PTR_W-1:0] rd_ptr_q;
	logic [JOBQ_CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full     = (count_q == JOBQ_CNT_W'(JOBQ_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = entry_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == JOBQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_job;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= JOBQ_CNT_W'(JOBQ_DEPTH))
		else $error("job queue count overflow");

endmodule

### hdl/pcm_back.sv
// ----------------------------------------------------------------------------
// pcm_back
// Walks a job's change masks slot by slot, one three-byte message per cycle
// while the output is empty or popped, into a single output register.
// ----------------------------------------------------------------------------
module pcm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  pcm_pkg::job_t                 job,
	output logic                          job_pop,
	input  logic [pcm_pkg::CHAN_W-1:0]    midi_channel,
	output logic                          empty,
	input  logic                          pop,
	output logic [7:0]                    status_byte,
	output logic [pcm_pkg::VALUE_W-1:0]   data_first,
	output logic [pcm_pkg::VALUE_W-1:0]   data_second,
	output logic                          last_message
);
	import pcm_pkg::*;

	logic                busy_q;
	job_t                job_q;
	logic                out_valid_q;
	logic [HW_SLOTS-1:0] pending;
	logic [SLOT_W-1:0]   sel;
	logic                is_cc;
	logic [HW_SLOTS-1:0] cc_n;
	logic [HW_SLOTS-1:0] tg_n;
	logic                last_n;
	logic [3:0]          chan;
	logic                load;
	logic                emit;

	assign load    = !busy_q && job_valid;
	assign job_pop = load;
	assign emit    = busy_q && (!out_valid_q || pop);
	assign empty   = !out_valid_q;

	// channel 1..16 maps to nibble 0..15, wrapping
	assign chan = midi_channel[3:0] + 4'hF;

	always_comb begin
		pending = job_q.cc_mask | job_q.tg_mask;
		sel = '0;
		for (int i = HW_SLOTS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				sel = SLOT_W'(i);
			end
		end
		is_cc = job_q.cc_mask[sel];
		cc_n  = job_q.cc_mask;
		tg_n  = job_q.tg_mask;
		// control change of a slot goes before its note
		if (is_cc) begin
			cc_n[sel] = 1'b0;
		end else begin
			tg_n[sel] = 1'b0;
		end
		last_n = !((|cc_n) || (|tg_n));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
			end else if (emit && last_n) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end else if (emit) begin
			job_q.cc_mask <= cc_n;
			job_q.tg_mask <= tg_n;
		end
		if (emit) begin
			last_message <= last_n;
			if (is_cc) begin
				status_byte <= ST_CTRL | {4'h0, chan};
				data_first  <= CTRL_BASE + VALUE_W'(sel);
				data_second <= job_q.ctrl_value[sel];
			end else if (job_q.trig[sel]) begin
				status_byte <= ST_NOTE_ON | {4'h0, chan};
				data_first  <= NOTE_BASE + VALUE_W'(sel);
				data_second <= VEL_ON;
			end else begin
				status_byte <= ST_NOTE_OFF | {4'h0, chan};
				data_first  <= NOTE_BASE + VALUE_W'(sel);
				data_second <= VEL_OFF;
			end
		end
	end

	a_last_ends_job: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_n) |=> !busy_q)
		else $error("job still busy after last word");

	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ((|job_q.cc_mask) || (|job_q.tg_mask)))
		else $error("busy with empty change masks");

	a_no_load_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !busy_q)
		else $error("job taken while previous job in progress");

endmodule

### hdl/param_change_to_midi_messages_core.sv
// ----------------------------------------------------------------------------
// param_change_to_midi_messages_core
// Turns per-frame controller and trigger snapshots into MIDI messages.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  frame in  push / full            ctrl_value_0..7, trigger_bits
//  message   empty / pop            status_byte, data_first, data_second,
//                                   last_message
//  config    cfg_valid / cfg_ready  midi_channel (always ready)
//
//  a frame is taken in one cycle while the two-entry job queue has room;
//  frames with no change leave no job and cause no word
//  the message unit loads a job only when idle, then gives one word per change,
//  one per cycle while the output is empty or popped, then takes the next job
//  a stalled pop holds the output register and backs up the queue, then full
//  reset clears the previous-frame values, the queue and the channel (to 1)
// ----------------------------------------------------------------------------
module param_change_to_midi_messages_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_0,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_1,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_2,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_3,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_4,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_5,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_6,
	input  logic [pcm_pkg::VALUE_W-1:0] ctrl_value_7,
	input  logic [7:0]                  trigger_bits,
	output logic                        empty,
	input  logic                        pop,
	output logic [7:0]                  status_byte,
	output logic [pcm_pkg::VALUE_W-1:0] data_first,
	output logic [pcm_pkg::VALUE_W-1:0] data_second,
	output logic                        last_message,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pcm_pkg::CHAN_W-1:0]  midi_channel
);
	import pcm_pkg::*;

	logic [CHAN_W-1:0] midi_channel_q;
	ctrl_vec_t         ctrl_value;
	logic              jobq_full;
	logic              job_push;
	job_t              job_in;
	logic              job_pop;
	logic              job_valid;
	job_t              job_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			midi_channel_q <= CHAN_RESET;
		end else if (cfg_valid) begin
			midi_channel_q <= midi_channel;
		end
	end

	assign ctrl_value = {ctrl_value_7, ctrl_value_6, ctrl_value_5, ctrl_value_4,
		ctrl_value_3, ctrl_value_2, ctrl_value_1, ctrl_value_0};

	pcm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.ctrl_value   (ctrl_value),
		.trigger_bits (trigger_bits),
		.jobq_full    (jobq_full),
		.job_push     (job_push),
		.job          (job_in)
	);

	pcm_job_fifo u_jobq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (job_push),
		.wr_job   (job_in),
		.full     (jobq_full),
		.rd_en    (job_pop),
		.rd_valid (job_valid),
		.rd_job   (job_out)
	);

	pcm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job          (job_out),
		.job_pop      (job_pop),
		.midi_channel (midi_channel_q),
		.empty        (empty),
		.pop          (pop),
		.status_byte  (status_byte),
		.data_first   (data_first),
		.data_second  (data_second),
		.last_message (last_message)
	);

endmodule
